// File: rtl/u8d_pkg.sv
package u8d_pkg;

   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned CP_WIDTH    = 21;
   localparam int unsigned COUNT_WIDTH = 2;
   localparam int unsigned CONT_BITS   = 6;

   localparam logic [COUNT_WIDTH-1:0] COUNT_NONE  = 2'd0;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = 2'd1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_TWO   = 2'd2;
   localparam logic [COUNT_WIDTH-1:0] COUNT_THREE = 2'd3;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] pending;
      logic [CP_WIDTH-1:0]    accum;
      logic                   emit;
      logic [CP_WIDTH-1:0]    code_point;
   } u8d_step_type;

endpackage

// File: rtl/u8d_if.sv
interface u8d_req_if;
   import u8d_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] byte_in;
   logic                  last_byte;

   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink (input valid, input byte_in, input last_byte, output ready);
endinterface

interface u8d_rsp_if;
   import u8d_pkg::*;

   logic                valid;
   logic                ready;
   logic [CP_WIDTH-1:0] code_point;

   modport source (output valid, output code_point, input ready);
   modport sink (input valid, input code_point, output ready);
endinterface

// File: rtl/u8d_decode.sv
module u8d_decode
   import u8d_pkg::*;
(
   input  logic [BYTE_WIDTH-1:0]  byte_in,
   input  logic [COUNT_WIDTH-1:0] pending,
   input  logic [CP_WIDTH-1:0]    accum,
   output u8d_step_type           step
);

   logic [COUNT_WIDTH-1:0] count_dec;
   logic [CP_WIDTH-1:0]    cont_bits;

   assign count_dec = pending - COUNT_ONE;

   always_comb begin
      case (count_dec)
         COUNT_NONE: cont_bits = {{(CP_WIDTH-CONT_BITS){1'b0}}, byte_in[CONT_BITS-1:0]};
         COUNT_ONE: cont_bits = {{(CP_WIDTH-2*CONT_BITS){1'b0}}, byte_in[CONT_BITS-1:0],
                                 {CONT_BITS{1'b0}}};
         default: cont_bits = {{(CP_WIDTH-3*CONT_BITS){1'b0}}, byte_in[CONT_BITS-1:0],
                               {(2*CONT_BITS){1'b0}}};
      endcase
   end

   always_comb begin
      step.pending    = pending;
      step.accum      = accum;
      step.emit       = 1'b0;
      step.code_point = accum | cont_bits;
      case (byte_in) inside
         [8'h00:8'h7F]: begin
            step.emit       = 1'b1;
            step.code_point = {{(CP_WIDTH-BYTE_WIDTH){1'b0}}, byte_in};
         end
         [8'hC0:8'hDF]: begin
            step.pending = COUNT_ONE;
            step.accum   = {10'd0, byte_in[4:0], 6'd0};
         end
         [8'hE0:8'hEF]: begin
            step.pending = COUNT_TWO;
            step.accum   = {5'd0, byte_in[3:0], 12'd0};
         end
         [8'hF0:8'hF7]: begin
            step.pending = COUNT_THREE;
            step.accum   = {byte_in[2:0], 18'd0};
         end
         [8'h80:8'hBF]: begin
            if (pending != COUNT_NONE) begin
               step.pending = count_dec;
               step.accum   = accum | cont_bits;
               step.emit    = (count_dec == COUNT_NONE);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/utf8_byte_decoder_top.sv
// UTF-8 byte decoder without validation. Each transfer on req_chan carries one byte, and a new
// byte can enter on every clock while ready is high; the byte that completes a code point (an
// ASCII byte or the last continuation byte) writes it into the output register that drives
// rsp_chan, or into the skid entry while that register is held. Lead bytes, inner continuation
// bytes, stray continuation bytes and 0xF8-0xFF produce no transfer. A two-entry output buffer
// keeps req_chan ready for one more byte while rsp_chan stalls; ready drops only when both
// entries hold code points. last_byte is carried but does not affect decoding.
module utf8_byte_decoder_top
   import u8d_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   u8d_req_if.sink   req_chan,
   u8d_rsp_if.source rsp_chan
);

   logic [COUNT_WIDTH-1:0] pending_ff, pending_in;
   logic [CP_WIDTH-1:0]    accum_ff, accum_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CP_WIDTH-1:0]    out_data_ff, out_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   logic [CP_WIDTH-1:0]    skid_data_ff, skid_data_in;

   u8d_step_type step;
   logic         req_fire;
   logic         emit;
   logic         rsp_fire;

   u8d_decode u_decode (
      .byte_in (req_chan.byte_in),
      .pending (pending_ff),
      .accum   (accum_ff),
      .step    (step)
   );

   assign req_chan.ready      = !skid_valid_ff;
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.code_point = out_data_ff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign emit     = req_fire && step.emit;
   assign rsp_fire = out_valid_ff && rsp_chan.ready;

   always_comb begin
      pending_in    = pending_ff;
      accum_in      = accum_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (req_fire) begin
         pending_in = step.pending;
         accum_in   = step.accum;
      end
      if (rsp_fire || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = emit;
            out_data_in  = step.code_point;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_data_in  = step.code_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= COUNT_NONE;
         accum_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         accum_ff      <= accum_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without head entry");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_chan.byte_in[BYTE_WIDTH-1]) |=> out_valid_ff)
      else $error("ASCII byte produced no code point");

   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_chan.byte_in[BYTE_WIDTH-1]) |=> $stable(pending_ff) && $stable(accum_ff))
      else $error("ASCII byte disturbed sequence state");

   assert property (@(posedge clock) disable iff (reset)
      $fell(out_valid_ff) |-> $past(rsp_chan.ready))
      else $error("code point dropped without transfer");

endmodule

// File: sim/testbench.sv
module testbench;
   import u8d_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASE_ITEMS  = 610;
   localparam int unsigned FLOOD_ITEMS  = 40;
   localparam int unsigned NUM_ROWS     = 27;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NONE,
      ROW_CP
   } row_kind_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data;
      logic                  last;
      row_kind_type          kind;
      logic [CP_WIDTH-1:0]   cp;
   } stim_row_type;

   logic clock;
   logic reset;

   u8d_req_if req_chan ();
   u8d_rsp_if rsp_chan ();

   utf8_byte_decoder_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   stim_row_type directed_rows [NUM_ROWS] = '{
      '{8'h80, 1'b0, ROW_NONE,    21'h000000},
      '{8'h00, 1'b0, ROW_CP,      21'h000000},
      '{8'h7f, 1'b1, ROW_CP,      21'h00007f},
      '{8'hc2, 1'b0, ROW_NONE,    21'h000000},
      '{8'ha9, 1'b0, ROW_CP,      21'h0000a9},
      '{8'hdf, 1'b1, ROW_NONE,    21'h000000},
      '{8'hbf, 1'b0, ROW_CP,      21'h0007ff},
      '{8'he2, 1'b0, ROW_NONE,    21'h000000},
      '{8'h82, 1'b0, ROW_NONE,    21'h000000},
      '{8'hac, 1'b1, ROW_CP,      21'h0020ac},
      '{8'hf7, 1'b0, ROW_NONE,    21'h000000},
      '{8'hbf, 1'b0, ROW_NONE,    21'h000000},
      '{8'hbf, 1'b1, ROW_NONE,    21'h000000},
      '{8'hbf, 1'b0, ROW_CP,      21'h1fffff},
      '{8'hbf, 1'b0, ROW_NONE,    21'h000000},
      '{8'he2, 1'b0, ROW_NONE,    21'h000000},
      '{8'h41, 1'b1, ROW_CP,      21'h000041},
      '{8'h82, 1'b0, ROW_NONE,    21'h000000},
      '{8'hac, 1'b0, ROW_PREDICT, 21'h000000},
      '{8'hf0, 1'b0, ROW_NONE,    21'h000000},
      '{8'h9f, 1'b0, ROW_NONE,    21'h000000},
      '{8'hc3, 1'b1, ROW_NONE,    21'h000000},
      '{8'ha9, 1'b0, ROW_PREDICT, 21'h000000},
      '{8'hf8, 1'b0, ROW_NONE,    21'h000000},
      '{8'hff, 1'b1, ROW_NONE,    21'h000000},
      '{8'hc0, 1'b0, ROW_NONE,    21'h000000},
      '{8'h80, 1'b0, ROW_PREDICT, 21'h000000}
   };

   logic [CP_WIDTH-1:0]    code_point_q [$];
   logic [COUNT_WIDTH-1:0] decode_pending;
   logic [CP_WIDTH-1:0]    decode_acc;
   logic                   step_emit;
   logic [CP_WIDTH-1:0]    step_cp;
   row_kind_type           drv_kind;
   logic [CP_WIDTH-1:0]    drv_cp;

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned sent_count     = 0;
   int unsigned req_idle_pct   = 0;
   int unsigned rsp_idle_pct   = 0;
   int unsigned hold_requests  = 0;
   int unsigned hold_seen      = 0;
   int unsigned hold_left      = 0;

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic decode_step(input logic [BYTE_WIDTH-1:0] data,
                              output logic emit, output logic [CP_WIDTH-1:0] cp);
      emit = 1'b0;
      cp   = '0;
      casez (data)
         8'b0???????: begin
            emit = 1'b1;
            cp   = CP_WIDTH'(data);
         end
         8'b110?????: begin
            decode_pending   = COUNT_ONE;
            decode_acc       = '0;
            decode_acc[10:6] = data[4:0];
         end
         8'b1110????: begin
            decode_pending    = COUNT_TWO;
            decode_acc        = '0;
            decode_acc[15:12] = data[3:0];
         end
         8'b11110???: begin
            decode_pending    = COUNT_THREE;
            decode_acc        = '0;
            decode_acc[20:18] = data[2:0];
         end
         8'b10??????: begin
            if (decode_pending != COUNT_NONE) begin
               decode_pending = decode_pending - 1'b1;
               decode_acc = decode_acc |
                            (CP_WIDTH'(data[5:0]) << (decode_pending * CONT_BITS));
               if (decode_pending == COUNT_NONE) begin
                  emit = 1'b1;
                  cp   = decode_acc;
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // predict on every accepted byte
   always @(posedge clock) begin
      if (reset) begin
         decode_pending = COUNT_NONE;
         decode_acc     = '0;
      end else if (req_chan.valid && req_chan.ready) begin
         decode_step(req_chan.byte_in, step_emit, step_cp);
         case (drv_kind)
            ROW_PREDICT: begin
               if (step_emit) code_point_q = {code_point_q, step_cp};
            end
            ROW_CP: begin
               code_point_q = {code_point_q, drv_cp};
            end
            default: begin
            end
         endcase
      end
   end

   // check every result transfer against the oldest expected code point
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (code_point_q.size() == 0) begin
            report_mismatch($sformatf("code_point %06h with nothing expected",
                                      rsp_chan.code_point));
         end else begin
            step_cp = code_point_q.pop_front();
            if (rsp_chan.code_point !== step_cp) begin
               report_mismatch($sformatf("code_point %06h, expected %06h",
                                         rsp_chan.code_point, step_cp));
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("utf8_byte_decoder_top regression: fail");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_WIDTH-1:0] data, input logic last,
                            input row_kind_type kind, input logic [CP_WIDTH-1:0] cp);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.byte_in   <= data;
      req_chan.last_byte <= last;
      drv_kind           <= kind;
      drv_cp             <= cp;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   task automatic send_pred(input logic [BYTE_WIDTH-1:0] data);
      send_byte(data, 1'($urandom_range(0, 1)), ROW_PREDICT, '0);
   endtask

   task automatic send_lead(input int unsigned len);
      case (len)
         2:       send_pred({3'b110, 5'($urandom_range(0, 31))});
         3:       send_pred({4'b1110, 4'($urandom_range(0, 15))});
         default: send_pred({5'b11110, 3'($urandom_range(0, 7))});
      endcase
   endtask

   task automatic send_conts(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) send_pred(8'($urandom_range(0, 127)));
         send_pred({2'b10, 6'($urandom_range(0, 63))});
      end
   endtask

   // mostly well-formed sequences with random payload, some truncated ones and noise
   task automatic random_traffic(input int unsigned target);
      int unsigned start;
      int unsigned pick;
      int unsigned len;
      int unsigned cut;
      start = sent_count;
      while (sent_count - start < target) begin
         pick = $urandom_range(0, 99);
         len  = $urandom_range(2, 4);
         if (pick < 25) begin
            send_pred(8'($urandom_range(0, 127)));
         end else if (pick < 80) begin
            send_lead(len);
            send_conts(len - 1);
         end else if (pick < 88) begin
            cut = $urandom_range(0, len - 2);
            send_lead(len);
            send_conts(cut);
         end else if (pick < 94) begin
            send_pred({2'b10, 6'($urandom_range(0, 63))});
         end else if (pick < 98) begin
            send_pred(8'($urandom_range(248, 255)));
         end else begin
            send_pred(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.byte_in   <= '0;
      req_chan.last_byte <= 1'b0;
      drv_kind           <= ROW_PREDICT;
      drv_cp             <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 21;
      rsp_idle_pct = 66;
      for (int unsigned i = 0; i < NUM_ROWS; i++) begin
         send_byte(directed_rows[i].data, directed_rows[i].last,
                   directed_rows[i].kind, directed_rows[i].cp);
      end
      random_traffic(PHASE_ITEMS);

      req_idle_pct = 66;
      rsp_idle_pct = 21;
      random_traffic(PHASE_ITEMS);

      // hold the receiver off while bytes keep coming, so the input stalls
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_requests++;
      for (int unsigned i = 0; i < FLOOD_ITEMS; i++) begin
         send_pred(8'($urandom_range(0, 127)));
      end
      random_traffic(PHASE_ITEMS - FLOOD_ITEMS);
      req_chan.valid <= 1'b0;

      while (code_point_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("utf8_byte_decoder_top regression: pass");
      end else begin
         $display("utf8_byte_decoder_top regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/u8d_pkg.sv
rtl/u8d_if.sv
rtl/u8d_decode.sv
rtl/utf8_byte_decoder_top.sv
sim/testbench.sv
